@@ design/eulw_pkg.sv @@
// Package for the Euler path edge walker: command codes and the fixed field widths.
// No dependencies; the interfaces and the top level refer to it by scoped names.
`default_nettype none

package eulw_pkg;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 3;
  localparam int LABEL_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_NODE  = 3'd0,
    CMD_SET_DIR   = 3'd1,
    CMD_SET_UNDIR = 3'd2,
    CMD_WALK      = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

endpackage

`default_nettype wire

@@ design/eulw_in_if.sv @@
// Command channel of the edge walker: valid/ready handshake and one command word.
// Depends on eulw_pkg for the field widths.
`default_nettype none

interface eulw_in_if;
  logic                          valid;
  logic                          ready;
  logic [eulw_pkg::CMD_W-1:0]    cmd;
  logic [eulw_pkg::LABEL_W-1:0]  node_label;
  logic [eulw_pkg::IDX_W-1:0]    row;
  logic [eulw_pkg::IDX_W-1:0]    col;
  logic                          edge_val;
  logic [eulw_pkg::IDX_W-1:0]    start_node;

  modport source (output valid, cmd, node_label, row, col, edge_val, start_node,
                  input ready);
  modport sink   (input valid, cmd, node_label, row, col, edge_val, start_node,
                  output ready);
endinterface

`default_nettype wire

@@ design/eulw_out_if.sv @@
// Result channel of the edge walker: valid/ready handshake and one result word.
// Depends on eulw_pkg for the field widths.
`default_nettype none

interface eulw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic                          has_node;
  logic [eulw_pkg::IDX_W-1:0]    out_index;
  logic [eulw_pkg::LABEL_W-1:0]  out_label;
  logic                          last;

  modport source (output valid, status, has_node, out_index, out_label, last,
                  input ready);
  modport sink   (input valid, status, has_node, out_index, out_label, last,
                  output ready);
endinterface

`default_nettype wire

@@ design/euler_path_edge_walk_top.sv @@
// Top level of the Euler path edge walker: graph store, walk sequencer, result register.
// Depends on eulw_pkg, eulw_in_if, eulw_out_if, eulw_scan and eulw_stack.
`default_nettype none

// Graph commands (add node, set edge, clear edges, and rejected words) each leave a
// single result word in the output register. A walk starts with a push of the start
// node, then pushes one node for each edge it consumes and pops each node in two steps
// (the pop with its result word in ST_SCAN, then a read of the new stack top from the
// stack memory in ST_LOAD), the final pop excepted, which returns straight to idle.
// Pops wait while the result side stalls. The registered read port of the stack
// memory is what makes the ST_LOAD step needed. The block takes no new word until a
// walk has emitted its last result word.
module euler_path_edge_walk_top #(
  parameter int MAX_NODES   = 8,
  parameter int LABEL_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eulw_in_if.sink   in_if,
  eulw_out_if.source out_if
);

  localparam int NW          = $clog2(MAX_NODES);
  localparam int CW          = $clog2(MAX_NODES + 1);
  localparam int XW          = (CW > eulw_pkg::IDX_W) ? CW : eulw_pkg::IDX_W;
  localparam int STACK_DEPTH = MAX_NODES * (MAX_NODES + 1) / 2 + 1;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int LW          = $clog2(STACK_DEPTH + 1);
  localparam int LS          = (LABEL_WIDTH < eulw_pkg::LABEL_W) ? LABEL_WIDTH
                                                                 : eulw_pkg::LABEL_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);
  localparam logic [CW-1:0] MAX_L   = CW'(MAX_NODES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD
  } state_e;

  state_e               state_q, state_d;
  logic [MAX_NODES-1:0] adj_q  [MAX_NODES];
  logic [MAX_NODES-1:0] adj_d  [MAX_NODES];
  logic [MAX_NODES-1:0] used_q [MAX_NODES];
  logic [MAX_NODES-1:0] used_d [MAX_NODES];
  logic [LS-1:0]        labels_q [MAX_NODES];
  logic [CW-1:0]        count_q, count_d;
  logic [LW-1:0]        level_q, level_d;
  logic [NW-1:0]        cur_q, cur_d;

  logic                            out_valid_q, out_valid_d;
  logic                            out_status_q, out_status_d;
  logic                            out_has_q, out_has_d;
  logic [eulw_pkg::IDX_W-1:0]      out_idx_q, out_idx_d;
  logic [eulw_pkg::LABEL_W-1:0]    out_label_q, out_label_d;
  logic                            out_last_q, out_last_d;

  logic          out_free, accept, label_we;
  logic          scan_found;
  logic [NW-1:0] scan_idx;
  logic          st_wr_en, st_rd_en;
  logic [AW-1:0] st_wr_addr, st_rd_addr;
  logic [NW-1:0] st_wr_data, st_rd_data;
  logic          pop_fire;
  logic [XW-1:0] row_x, col_x, start_x, count_x;
  logic [NW-1:0] row_n, col_n;

  assign out_free    = !out_valid_q || out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;

  assign row_x   = XW'(in_if.row);
  assign col_x   = XW'(in_if.col);
  assign start_x = XW'(in_if.start_node);
  assign count_x = XW'(count_q);
  assign row_n   = NW'(in_if.row);
  assign col_n   = NW'(in_if.col);

  eulw_scan #(
    .MAX_NODES(MAX_NODES)
  ) u_scan (
    .adj_row_i   (adj_q[cur_q]),
    .used_row_i  (used_q[cur_q]),
    .node_count_i(count_q),
    .found_o     (scan_found),
    .idx_o       (scan_idx)
  );

  eulw_stack #(
    .DEPTH(STACK_DEPTH),
    .DW   (NW)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (st_wr_en),
    .wr_addr_i(st_wr_addr),
    .wr_data_i(st_wr_data),
    .rd_en_i  (st_rd_en),
    .rd_addr_i(st_rd_addr),
    .rd_data_o(st_rd_data)
  );

  // A pop happens when the top node has no unused edge left (or the stack is full) and the result slot is free.
  assign pop_fire = (state_q == ST_SCAN) && !(scan_found && (level_q < DEPTH_L)) && out_free;

  always_comb begin
    state_d      = state_q;
    adj_d        = adj_q;
    used_d       = used_q;
    count_d      = count_q;
    level_d      = level_q;
    cur_d        = cur_q;
    out_valid_d  = out_valid_q && !out_if.ready;
    out_status_d = out_status_q;
    out_has_d    = out_has_q;
    out_idx_d    = out_idx_q;
    out_label_d  = out_label_q;
    out_last_d   = out_last_q;
    label_we     = 1'b0;
    st_wr_en     = 1'b0;
    st_wr_addr   = AW'(level_q);
    st_wr_data   = scan_idx;
    st_rd_en     = 1'b0;
    st_rd_addr   = AW'(level_q - LW'(2));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_status_d = eulw_pkg::STATUS_OK;
          out_has_d    = 1'b0;
          out_idx_d    = '0;
          out_label_d  = '0;
          out_last_d   = 1'b1;
          case (in_if.cmd)
            eulw_pkg::CMD_ADD_NODE: begin
              if (count_q >= MAX_L) begin
                out_status_d = eulw_pkg::STATUS_REJ;
              end else begin
                label_we = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            eulw_pkg::CMD_SET_DIR, eulw_pkg::CMD_SET_UNDIR: begin
              if ((row_x >= count_x) || (col_x >= count_x)) begin
                out_status_d = eulw_pkg::STATUS_REJ;
              end else begin
                adj_d[row_n][col_n] = in_if.edge_val;
                if (in_if.cmd == eulw_pkg::CMD_SET_UNDIR) begin
                  adj_d[col_n][row_n] = in_if.edge_val;
                end
              end
            end
            eulw_pkg::CMD_WALK: begin
              if (start_x >= count_x) begin
                out_status_d = eulw_pkg::STATUS_REJ;
              end else begin
                out_valid_d = out_valid_q && !out_if.ready;
                for (int r = 0; r < MAX_NODES; r++) begin
                  used_d[r] = '0;
                end
                st_wr_en   = 1'b1;
                st_wr_addr = '0;
                st_wr_data = NW'(in_if.start_node);
                cur_d      = NW'(in_if.start_node);
                level_d    = LW'(1);
                state_d    = ST_SCAN;
              end
            end
            eulw_pkg::CMD_CLEAR: begin
              for (int r = 0; r < MAX_NODES; r++) begin
                adj_d[r] = '0;
              end
            end
            default: begin
              out_status_d = eulw_pkg::STATUS_REJ;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (scan_found && (level_q < DEPTH_L)) begin
          used_d[cur_q][scan_idx] = 1'b1;
          used_d[scan_idx][cur_q] = 1'b1;
          st_wr_en = 1'b1;
          level_d  = level_q + LW'(1);
          cur_d    = scan_idx;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = eulw_pkg::STATUS_OK;
          out_has_d    = 1'b1;
          out_idx_d    = eulw_pkg::IDX_W'(cur_q);
          out_label_d  = eulw_pkg::LABEL_W'(labels_q[cur_q]);
          out_last_d   = (level_q == LW'(1));
          level_d      = level_q - LW'(1);
          if (level_q == LW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            st_rd_en = 1'b1;
            state_d  = ST_LOAD;
          end
        end
      end

      ST_LOAD: begin
        cur_d   = st_rd_data;
        state_d = ST_SCAN;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      level_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
      for (int r = 0; r < MAX_NODES; r++) begin
        adj_q[r]  <= '0;
        used_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      level_q     <= level_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
      adj_q       <= adj_d;
      used_q      <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_has_q    <= out_has_d;
    out_idx_q    <= out_idx_d;
    out_label_q  <= out_label_d;
    out_last_q   <= out_last_d;
    if (label_we) begin
      labels_q[NW'(count_q)] <= LS'(in_if.node_label);
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.status    = out_status_q;
  assign out_if.has_node  = out_has_q;
  assign out_if.out_index = out_idx_q;
  assign out_if.out_label = out_label_q;
  assign out_if.last      = out_last_q;

`ifndef ASSERT_OFF
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= DEPTH_L)
    else $error("walk stack level beyond its depth");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (level_q == '0))
    else $error("stack not empty while idle");

  a_last_pop_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_fire && (level_q == LW'(1))) |=> (state_q == ST_IDLE) && out_last_q)
    else $error("final pop did not end the walk");

  a_load_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> ($past(pop_fire) && !out_last_q))
    else $error("stack reload without a pop");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_L)
    else $error("node count beyond capacity");
`endif

endmodule

`default_nettype wire

@@ design/eulw_scan.sv @@
// Neighbor scan unit: finds the lowest-index unused edge in one adjacency row.
// Shared by every walk step; depends on nothing but its parameter.
`default_nettype none

module eulw_scan #(
  parameter int MAX_NODES = 8
) (
  input  wire logic [MAX_NODES-1:0]                 adj_row_i,
  input  wire logic [MAX_NODES-1:0]                 used_row_i,
  input  wire logic [$clog2(MAX_NODES+1)-1:0]       node_count_i,
  output logic                                      found_o,
  output logic [$clog2(MAX_NODES)-1:0]              idx_o
);

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int NW = $clog2(MAX_NODES);

  logic [MAX_NODES-1:0] cand;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      cand[i] = adj_row_i[i] && !used_row_i[i] && (CW'(i) < node_count_i);
    end
  end

  // Walk from the top down so that the lowest candidate wins.
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found_o = 1'b1;
        idx_o   = NW'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/eulw_stack.sv @@
// Walk stack memory: one write port and one registered read port.
// Stand-alone; the sequencer in the top level keeps the stack pointer.
`default_nettype none

module eulw_stack #(
  parameter int DEPTH = 37,
  parameter int DW    = 3
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [DW-1:0]            wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [DW-1:0]            rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
